// File: rtl/core/ttd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttd_pkg
// types and constants shared by the tiled texture texel decoder
// ----------------------------------------------------------------------------
package ttd_pkg;

    localparam int MAX_DIMENSION = 16384;

    localparam logic [3:0] FMT_I4     = 4'd0;
    localparam logic [3:0] FMT_I8     = 4'd1;
    localparam logic [3:0] FMT_IA4    = 4'd2;
    localparam logic [3:0] FMT_IA8    = 4'd3;
    localparam logic [3:0] FMT_RGB565 = 4'd4;
    localparam logic [3:0] FMT_RGB5A3 = 4'd5;
    localparam logic [3:0] FMT_RGBA8  = 4'd6;
    localparam logic [3:0] FMT_CMPR   = 4'd14;

    localparam logic [1:0] REG_FORMAT = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    // one queued word: up to four pixels of one input byte
    typedef struct packed {
        logic [3:0]      px_en;
        logic [3:0][2:0] dx;
        logic [2:0]      dy;
        logic [3:0][7:0] r;
        logic [3:0][7:0] g;
        logic [3:0][7:0] b;
        logic [3:0][7:0] a;
        logic            err;
    } job_t;

    function automatic logic [7:0] sc4(input logic [3:0] v);
        return {v, v};
    endfunction

    // v*255/31 = 8v + floor(7v/31)
    function automatic logic [7:0] sc5(input logic [4:0] v);
        logic [2:0] f;
        f = 3'(v >= 5'd5) + 3'(v >= 5'd9) + 3'(v >= 5'd14) + 3'(v >= 5'd18)
          + 3'(v >= 5'd23) + 3'(v >= 5'd27) + 3'(v >= 5'd31);
        return {v, 3'b000} + {5'b00000, f};
    endfunction

    // v*255/63 = 4v + floor(v/21)
    function automatic logic [7:0] sc6(input logic [5:0] v);
        logic [1:0] f;
        f = 2'(v >= 6'd21) + 2'(v >= 6'd42) + 2'(v >= 6'd63);
        return {v, 2'b00} + {6'b000000, f};
    endfunction

    // v*255/7 = 36v + floor(3v/7)
    function automatic logic [7:0] sc3(input logic [2:0] v);
        logic [1:0] f;
        f = 2'(v >= 3'd3) + 2'(v >= 3'd5) + 2'(v == 3'd7);
        return {v, 5'b00000} + {3'b000, v, 2'b00} + {6'b000000, f};
    endfunction

    // truncating divide by three for values below 766
    function automatic logic [7:0] div3(input logic [9:0] v);
        logic [19:0] p;
        p = v * 10'd683;
        return p[18:11];
    endfunction

endpackage

// File: rtl/core/tiled_texture_texel_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiled_texture_texel_decoder_unit
// decodes a tiled texture body byte stream into positioned rgba pixels
// ----------------------------------------------------------------------------
// s_ channel takes one body byte per word; m_ channel gives one pixel per word.
// cfg channel writes format (0), width (1), height (2) while idle; a write to
// one of these restarts the image at the top-left tile, one to index 3 is ignored.
// the front decodes a byte in the cycle it is accepted and, if the byte yields
// pixels or a format error, pushes one job of up to four pixels into a two-entry
// queue; the back emits one pixel a cycle, while the receiver keeps up, from the
// head job into an output register. an i4 byte yields two pixels, a cmpr index
// row four, others at most one; a pixel passes the queue and the output register.
// m_tlast marks the last pixel of one byte, m_tuser marks a format error
// word with zero pixel fields. reset clears counters and restores format 0,
// 1x1 image. a stalled receiver holds the output word and fills the queue,
// after which s_tready drops.
// ----------------------------------------------------------------------------
module tiled_texture_texel_decoder_unit
    import ttd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [14:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // body_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // pixel_x, pixel_y, red, green, blue, alpha, image_done
    output logic        m_tlast,   // last_of_item
    output logic        m_tuser    // format_error
);

    job_t        fj, qj;
    logic        fv, fr, qv, qr, rst;
    logic [13:0] fc, fro, qc, qro;
    logic [14:0] we, he;

    assign cfg_ready = 1'b1;

    ttd_front u_front (
        .aclk, .aresetn, .cfg_valid, .cfg_index, .cfg_data,
        .s_tvalid, .s_tready, .s_tdata,
        .q_ready(fr), .q_valid(fv), .q_job(fj), .q_col(fc), .q_row(fro),
        .width_eff(we), .height_eff(he), .restart(rst)
    );

    ttd_queue u_queue (
        .aclk, .aresetn,
        .in_valid(fv), .in_ready(fr), .in_job(fj), .in_col(fc), .in_row(fro),
        .out_valid(qv), .out_ready(qr), .out_job(qj), .out_col(qc), .out_row(qro)
    );

    ttd_back u_back (
        .aclk, .aresetn, .restart(rst), .width_eff(we), .height_eff(he),
        .j_valid(qv), .j_ready(qr), .j_job(qj), .j_col(qc), .j_row(qro),
        .m_tvalid, .m_tready, .m_tdata, .m_tlast, .m_tuser
    );

endmodule

// File: rtl/core/ttd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttd_front
// per-byte decode: tile counters, buffers and channel scaling into jobs
// ----------------------------------------------------------------------------
module ttd_front
    import ttd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic [1:0]  cfg_index,
    input  logic [14:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        q_ready,
    output logic        q_valid,
    output job_t        q_job,
    output logic [13:0] q_col,
    output logic [13:0] q_row,
    output logic [14:0] width_eff,
    output logic [14:0] height_eff,
    output logic        restart
);

    logic [3:0]  fmt_reg;
    logic [14:0] w_reg, h_reg;
    logic [14:0] col_reg, row_reg;
    logic [5:0]  bib_reg;
    logic [1:0]  sub_reg;
    logic [7:0]  held_reg;
    logic [15:0] ep_reg [2];
    logic [15:0] ar_mem [16];
    logic        fin_reg;

    function automatic logic [14:0] eff(input logic [14:0] v);
        if (v == '0) return 15'd1;
        if (32'(v) > MAX_DIMENSION) return 15'(MAX_DIMENSION);
        return v;
    endfunction

    assign width_eff = eff(w_reg);
    assign height_eff = eff(h_reg);
    assign restart = cfg_valid && (cfg_index <= REG_HEIGHT);
    assign s_tready = q_ready;

    logic acc, bad;
    assign acc = s_tvalid && s_tready;
    assign bad = (fmt_reg > FMT_RGBA8) && (fmt_reg != FMT_CMPR);

    logic [7:0]  v;
    logic [5:0]  b;
    logic [15:0] word;
    logic [3:0]  k;
    job_t        j;
    logic        adv;
    logic [3:0]  tw, th;
    logic [7:0]  p0[3], p1[3], p2[3], p3[3];
    logic        four;
    logic [1:0]  idx;

    always_comb begin
        v = s_tdata;
        b = bib_reg;
        word = {held_reg, v};
        k = b[4:1];
        j = '0;
        adv = 1'b0;
        tw = 4'd4;
        th = 4'd4;
        idx = '0;
        four = ep_reg[0] > ep_reg[1];
        p0[0] = sc5(ep_reg[0][15:11]);
        p0[1] = sc6(ep_reg[0][10:5]);
        p0[2] = sc5(ep_reg[0][4:0]);
        p1[0] = sc5(ep_reg[1][15:11]);
        p1[1] = sc6(ep_reg[1][10:5]);
        p1[2] = sc5(ep_reg[1][4:0]);
        for (int c = 0; c < 3; c++) begin
            if (four) begin
                p2[c] = div3({1'b0, p0[c], 1'b0} + 10'(p1[c]));
                p3[c] = div3(10'(p0[c]) + {1'b0, p1[c], 1'b0});
            end else begin
                p2[c] = 8'((9'(p0[c]) + 9'(p1[c])) >> 1);
                p3[c] = '0;
            end
        end
        j.err = bad;
        if (bad) begin
            j.px_en = '0;
        end else begin
            unique case (fmt_reg)
                FMT_I4: begin
                    j.dy = b[4:2];
                    j.dx[0] = {b[1:0], 1'b0};
                    j.dx[1] = {b[1:0], 1'b1};
                    j.r[0] = sc4(v[7:4]); j.g[0] = j.r[0]; j.b[0] = j.r[0];
                    j.r[1] = sc4(v[3:0]); j.g[1] = j.r[1]; j.b[1] = j.r[1];
                    j.a[0] = 8'hff; j.a[1] = 8'hff;
                    j.px_en = 4'b0011;
                    adv = (b[4:0] == 5'd31);
                    tw = 4'd8; th = 4'd8;
                end
                FMT_I8, FMT_IA4: begin
                    j.dy = {1'b0, b[4:3]};
                    j.dx[0] = b[2:0];
                    if (fmt_reg == FMT_I8) begin
                        j.r[0] = v; j.a[0] = 8'hff;
                    end else begin
                        j.r[0] = sc4(v[3:0]); j.a[0] = sc4(v[7:4]);
                    end
                    j.g[0] = j.r[0]; j.b[0] = j.r[0];
                    j.px_en = 4'b0001;
                    adv = (b[4:0] == 5'd31);
                    tw = 4'd8;
                end
                FMT_IA8, FMT_RGB565, FMT_RGB5A3: begin
                    j.dy = {1'b0, k[3:2]};
                    j.dx[0] = {1'b0, k[1:0]};
                    j.a[0] = 8'hff;
                    if (fmt_reg == FMT_IA8) begin
                        j.r[0] = v; j.g[0] = v; j.b[0] = v; j.a[0] = held_reg;
                    end else if (fmt_reg == FMT_RGB565) begin
                        j.r[0] = sc5(word[15:11]); j.g[0] = sc6(word[10:5]);
                        j.b[0] = sc5(word[4:0]);
                    end else if (word[15]) begin
                        j.r[0] = sc5(word[14:10]); j.g[0] = sc5(word[9:5]);
                        j.b[0] = sc5(word[4:0]);
                    end else begin
                        j.r[0] = sc4(word[11:8]); j.g[0] = sc4(word[7:4]);
                        j.b[0] = sc4(word[3:0]); j.a[0] = sc3(word[14:12]);
                    end
                    j.px_en = {3'b000, b[0]};
                    adv = (b[4:0] == 5'd31);
                end
                FMT_RGBA8: begin
                    j.dy = {1'b0, k[3:2]};
                    j.dx[0] = {1'b0, k[1:0]};
                    j.r[0] = ar_mem[k][7:0];
                    j.a[0] = ar_mem[k][15:8];
                    j.g[0] = held_reg;
                    j.b[0] = v;
                    j.px_en = {3'b000, b[0] & b[5]};
                    adv = (b == 6'd63);
                end
                FMT_CMPR: begin
                    for (int x = 0; x < 4; x++) begin
                        j.dx[x] = {sub_reg[0], 2'(x)};
                        idx = v[7 - 2 * x -: 2];
                        unique case (idx)
                            2'd0: begin j.r[x] = p0[0]; j.g[x] = p0[1]; j.b[x] = p0[2]; end
                            2'd1: begin j.r[x] = p1[0]; j.g[x] = p1[1]; j.b[x] = p1[2]; end
                            2'd2: begin j.r[x] = p2[0]; j.g[x] = p2[1]; j.b[x] = p2[2]; end
                            default: begin
                                j.r[x] = p3[0]; j.g[x] = p3[1]; j.b[x] = p3[2];
                            end
                        endcase
                        j.a[x] = (idx == 2'd3 && !four) ? 8'h00 : 8'hff;
                    end
                    j.dy = {sub_reg[1], 2'(b[1:0])};
                    j.px_en = b[2] ? 4'b1111 : 4'b0000;
                    adv = (b[2:0] == 3'd7) && (sub_reg == 2'd3);
                    tw = 4'd8; th = 4'd8;
                end
                default: j.px_en = '0;
            endcase
        end
    end

    // a finished image drops whole bytes; bad format always emits
    assign q_valid = acc && (bad || (!fin_reg && j.px_en != '0));
    assign q_job = j;
    assign q_col = col_reg[13:0];
    assign q_row = row_reg[13:0];

    logic [14:0] col_next, row_next;
    logic        fin_next;

    always_comb begin
        col_next = col_reg + 15'(tw);
        row_next = row_reg;
        fin_next = fin_reg;
        if (col_next >= width_eff) begin
            col_next = '0;
            row_next = row_reg + 15'(th);
            if (row_next >= height_eff) begin
                row_next = '0;
                fin_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg <= FMT_I4;
            w_reg <= 15'd1;
            h_reg <= 15'd1;
            col_reg <= '0;
            row_reg <= '0;
            bib_reg <= '0;
            sub_reg <= '0;
            held_reg <= '0;
            fin_reg <= 1'b0;
        end else if (restart) begin
            unique case (cfg_index)
                REG_FORMAT: fmt_reg <= cfg_data[3:0];
                REG_WIDTH:  w_reg <= cfg_data;
                default:    h_reg <= cfg_data;
            endcase
            col_reg <= '0;
            row_reg <= '0;
            bib_reg <= '0;
            sub_reg <= '0;
            held_reg <= '0;
            fin_reg <= 1'b0;
        end else if (acc && !bad && !fin_reg) begin
            if (!b[0]) held_reg <= v;
            if (fmt_reg == FMT_CMPR) begin
                bib_reg <= (b[2:0] == 3'd7) ? 6'd0 : b + 6'd1;
                if (b[2:0] == 3'd7) sub_reg <= sub_reg + 2'd1;
            end else begin
                bib_reg <= adv ? 6'd0 : b + 6'd1;
            end
            if (adv) begin
                col_reg <= col_next;
                row_reg <= row_next;
                fin_reg <= fin_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (acc && !bad && !fin_reg && !restart) begin
            if (fmt_reg == FMT_CMPR && b[2:1] == 2'b00 && b[0])
                ep_reg[0] <= word;
            if (fmt_reg == FMT_CMPR && b[2:1] == 2'b01 && b[0])
                ep_reg[1] <= word;
            if (fmt_reg == FMT_RGBA8 && b[0] && !b[5])
                ar_mem[k] <= word;
        end
    end

endmodule

// File: rtl/core/ttd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttd_queue
// two-entry queue of decoded jobs between the front and the pixel emitter
// ----------------------------------------------------------------------------
module ttd_queue
    import ttd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  job_t        in_job,
    input  logic [13:0] in_col,
    input  logic [13:0] in_row,
    output logic        out_valid,
    input  logic        out_ready,
    output job_t        out_job,
    output logic [13:0] out_col,
    output logic [13:0] out_row
);

    job_t        job_mem [2];
    logic [13:0] col_mem [2];
    logic [13:0] row_mem [2];
    logic        wp_reg, rp_reg;
    logic [1:0]  cnt_reg;

    assign in_ready = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_job = job_mem[rp_reg];
    assign out_col = col_mem[rp_reg];
    assign out_row = row_mem[rp_reg];

    logic wr, rd;
    assign wr = in_valid && in_ready;
    assign rd = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= !wp_reg;
            if (rd) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr) begin
            job_mem[wp_reg] <= in_job;
            col_mem[wp_reg] <= in_col;
            row_mem[wp_reg] <= in_row;
        end
    end

endmodule

// File: rtl/core/ttd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttd_back
// walks the pixels of one job, drops those outside the image, emits one per cycle unless stalled
// ----------------------------------------------------------------------------
module ttd_back
    import ttd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        restart,
    input  logic [14:0] width_eff,
    input  logic [14:0] height_eff,
    input  logic        j_valid,
    output logic        j_ready,
    input  job_t        j_job,
    input  logic [13:0] j_col,
    input  logic [13:0] j_row,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,
    output logic        m_tlast,
    output logic        m_tuser
);

    logic [3:0]  done_reg;   // pixels of the head job already handled
    logic        fin_reg;
    logic        ov_reg;
    logic [60:0] od_reg;
    logic        ol_reg, oe_reg;

    logic [3:0]  inb;
    logic [14:0] x[4], y;
    logic [3:0]  pend;
    logic [1:0]  sel;
    logic [3:0]  after;
    logic        have, last, corner, slot;

    always_comb begin
        y = 15'(j_row) + 15'(j_job.dy);
        for (int i = 0; i < 4; i++) begin
            x[i] = 15'(j_col) + 15'(j_job.dx[i]);
            inb[i] = j_job.px_en[i] && x[i] < width_eff && y < height_eff;
        end
        pend = inb & ~done_reg;
        if (fin_reg) pend = '0;
        sel = pend[0] ? 2'd0 : pend[1] ? 2'd1 : pend[2] ? 2'd2 : 2'd3;
        have = pend != '0;
        after = pend & ~(4'b0001 << sel) & ~((4'b0001 << sel) - 4'd1);
        corner = x[sel] == width_eff - 15'd1 && y == height_eff - 15'd1;
        last = after == '0 || corner;
        slot = !ov_reg || m_tready;
    end

    // a job retires with its last pixel, when none remain, or (error) once the output is free
    assign j_ready = j_job.err ? slot : (!have || (slot && last));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= '0;
            fin_reg <= 1'b0;
            ov_reg <= 1'b0;
        end else begin
            if (j_valid && slot && (j_job.err || have)) ov_reg <= 1'b1;
            else if (m_tready) ov_reg <= 1'b0;
            if (restart) fin_reg <= 1'b0;
            else if (j_valid && slot && !j_job.err && have && corner) fin_reg <= 1'b1;
            if (j_valid && slot && !j_job.err && have)
                done_reg <= last ? 4'b0000 : done_reg | (4'b0001 << sel);
        end
    end

    always_ff @(posedge aclk) begin
        if (j_valid && slot) begin
            oe_reg <= j_job.err;
            if (j_job.err) begin
                ol_reg <= 1'b1;
                od_reg <= '0;
            end else begin
                ol_reg <= last;
                od_reg <= {corner, j_job.a[sel], j_job.b[sel], j_job.g[sel],
                           j_job.r[sel], y[13:0], x[sel][13:0]};
            end
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata = {3'b000, od_reg};
    assign m_tlast = ol_reg;
    assign m_tuser = oe_reg;

endmodule

// File: rtl/core/ttd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttd_checker
// port-level checks of the texel decoder
// ----------------------------------------------------------------------------
module ttd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed under stall");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0 && m_tlast)
        else $error("error word carries pixel data");

    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[60] |-> m_tlast)
        else $error("image done not last of byte");

    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[63:61] == 3'b000)
        else $error("pad bit set");

endmodule

bind tiled_texture_texel_decoder_unit ttd_checker u_ttd_checker (.*);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// testbench for the tiled texture texel decoder unit
// ----------------------------------------------------------------------------
// body bytes go in on the s_ channel in bursts with random gaps. each accepted
// byte runs through a behavioral decoder in the testbench, which queues the
// pixels it should produce. every pixel word on the m_ channel is compared
// field by field with the oldest queued pixel. the receiver stalls on a
// changing pattern and once holds off long enough to back up the input.
// directed tests cover each format, two unsupported codes, finished images,
// dimension clamping and the ignored register index; a random part follows.
// ----------------------------------------------------------------------------
module tb_top;
    import ttd_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int MAX_DIM = 16384;
    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [13:0] x;
        logic [13:0] y;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [7:0]  a;
        logic        done;
        logic        last;
        logic        err;
    } pixel_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [14:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    tiled_texture_texel_decoder_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // decoder state mirrored in the testbench
    logic [3:0]  tex_fmt;
    logic [14:0] img_w;
    logic [14:0] img_h;
    int          col_org;
    int          row_org;
    int          blk_byte;
    int          sub_blk;
    int          held;
    int          endpoint[2];
    int          ar_store[16];
    bit          img_done;

    pixel_t pixel_q[$];
    int     errors;
    int     idle_cycles;
    int     burst_left;
    bit     hold_req;
    int     hold_cnt;
    int     pat_mode;
    int     pat_left;

    function automatic int eff_dim(input int v);
        if (v == 0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return v;
    endfunction

    function automatic int scale(input int v, input int max);
        return (v * 255) / max;
    endfunction

    function automatic void restart_image();
        col_org = 0;
        row_org = 0;
        blk_byte = 0;
        sub_blk = 0;
        held = 0;
        img_done = 0;
    endfunction

    function automatic void emit(input int dx, input int dy, input int r, input int g,
                                 input int b, input int a);
        int w;
        int h;
        int x;
        int y;
        pixel_t p;
        w = eff_dim(img_w);
        h = eff_dim(img_h);
        x = col_org + dx;
        y = row_org + dy;
        if (img_done || x >= w || y >= h) return;
        p = '0;
        p.x = x[13:0];
        p.y = y[13:0];
        p.r = r[7:0];
        p.g = g[7:0];
        p.b = b[7:0];
        p.a = a[7:0];
        p.done = (x == w - 1 && y == h - 1);
        if (p.done) img_done = 1;
        pixel_q.push_back(p);
    endfunction

    function automatic void advance_tile(input int tw, input int th);
        blk_byte = 0;
        col_org += tw;
        if (col_org >= eff_dim(img_w)) begin
            col_org = 0;
            row_org += th;
            if (row_org >= eff_dim(img_h)) begin
                row_org = 0;
                img_done = 1;
            end
        end
    endfunction

    function automatic void unpack565(input int p, output int c[3]);
        c[0] = scale((p >> 11) & 31, 31);
        c[1] = scale((p >> 5) & 63, 63);
        c[2] = scale(p & 31, 31);
    endfunction

    function automatic void decode_index_row(input int rowbits, input int dy);
        int pal[4][4];
        int c0[3];
        int c1[3];
        int k;
        int sx;
        int sy;
        bit four;
        four = endpoint[0] > endpoint[1];
        unpack565(endpoint[0], c0);
        unpack565(endpoint[1], c1);
        sx = (sub_blk & 1) * 4;
        sy = (sub_blk >> 1) * 4;
        for (int c = 0; c < 3; c++) begin
            pal[0][c] = c0[c];
            pal[1][c] = c1[c];
            if (four) begin
                pal[2][c] = (2 * c0[c] + c1[c]) / 3;
                pal[3][c] = (c0[c] + 2 * c1[c]) / 3;
            end else begin
                pal[2][c] = (c0[c] + c1[c]) / 2;
                pal[3][c] = 0;
            end
        end
        pal[0][3] = 255;
        pal[1][3] = 255;
        pal[2][3] = 255;
        pal[3][3] = four ? 255 : 0;
        for (int x = 0; x < 4; x++) begin
            k = (rowbits >> (6 - 2 * x)) & 3;
            emit(sx + x, sy + dy, pal[k][0], pal[k][1], pal[k][2], pal[k][3]);
        end
    endfunction

    // returns 1 when the byte is ignored because the image is complete
    function automatic bit decode_byte(input logic [7:0] byte_in);
        int v;
        int b;
        int n0;
        int i;
        int k;
        int wd;
        int c[3];
        int a;
        pixel_t p;
        v = byte_in;
        b = blk_byte & 63;
        n0 = pixel_q.size();
        if (tex_fmt > FMT_RGBA8 && tex_fmt != FMT_CMPR) begin
            p = '0;
            p.last = 1;
            p.err = 1;
            pixel_q.push_back(p);
            return 0;
        end
        if (img_done) return 1;
        case (tex_fmt)
            FMT_I4: begin
                i = scale(v >> 4, 15);
                emit((b & 3) * 2, b >> 2, i, i, i, 255);
                i = scale(v & 15, 15);
                emit((b & 3) * 2 + 1, b >> 2, i, i, i, 255);
                blk_byte = b + 1;
                if (blk_byte == 32) advance_tile(8, 8);
            end
            FMT_I8, FMT_IA4: begin
                if (tex_fmt == FMT_I8) emit(b & 7, b >> 3, v, v, v, 255);
                else begin
                    i = scale(v & 15, 15);
                    emit(b & 7, b >> 3, i, i, i, scale(v >> 4, 15));
                end
                blk_byte = b + 1;
                if (blk_byte == 32) advance_tile(8, 4);
            end
            FMT_IA8, FMT_RGB565, FMT_RGB5A3: begin
                if ((b & 1) == 0) held = v;
                else begin
                    a = 255;
                    k = b >> 1;
                    wd = (held << 8) | v;
                    if (tex_fmt == FMT_IA8) begin
                        c[0] = v;
                        c[1] = v;
                        c[2] = v;
                        a = held;
                    end else if (tex_fmt == FMT_RGB565) unpack565(wd, c);
                    else if (wd & 'h8000) begin
                        c[0] = scale((wd >> 10) & 31, 31);
                        c[1] = scale((wd >> 5) & 31, 31);
                        c[2] = scale(wd & 31, 31);
                    end else begin
                        c[0] = scale((wd >> 8) & 15, 15);
                        c[1] = scale((wd >> 4) & 15, 15);
                        c[2] = scale(wd & 15, 15);
                        a = scale((wd >> 12) & 7, 7);
                    end
                    emit(k & 3, k >> 2, c[0], c[1], c[2], a);
                end
                blk_byte = b + 1;
                if (blk_byte == 32) advance_tile(4, 4);
            end
            FMT_RGBA8: begin
                k = (b >> 1) & 15;
                if ((b & 1) == 0) held = v;
                else if (b < 32) ar_store[k] = (held << 8) | v;
                else emit(k & 3, k >> 2, ar_store[k] & 255, held, v,
                          (ar_store[k] >> 8) & 255);
                blk_byte = b + 1;
                if (blk_byte == 64) advance_tile(4, 4);
            end
            default: begin
                if (b < 4) begin
                    if ((b & 1) == 0) held = v;
                    else endpoint[b >> 1] = (held << 8) | v;
                end else decode_index_row(v, (b - 4) & 3);
                blk_byte = b + 1;
                if (blk_byte >= 8) begin
                    blk_byte = 0;
                    sub_blk = (sub_blk + 1) & 3;
                    if (sub_blk == 0) advance_tile(8, 8);
                end
            end
        endcase
        if (pixel_q.size() > n0) pixel_q[pixel_q.size() - 1].last = 1;
        return 0;
    endfunction

    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        burst_left = 0;
        while (pixel_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
        wait_idle();
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_FORMAT: begin tex_fmt = val[3:0]; restart_image(); end
            REG_WIDTH:  begin img_w = val; restart_image(); end
            REG_HEIGHT: begin img_h = val; restart_image(); end
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic setup_image(input logic [3:0] f, input int w, input int h);
        write_reg(REG_FORMAT, 15'(f));
        write_reg(REG_WIDTH, 15'(w));
        write_reg(REG_HEIGHT, 15'(h));
    endtask

    task automatic send_byte(input logic [7:0] v, output bit ignored);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid = 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata = v;
        do @(posedge aclk); while (!s_tready);
        ignored = decode_byte(v);
        burst_left--;
    endtask

    task automatic send_list(input logic [7:0] bytes[$]);
        bit ign;
        foreach (bytes[i]) send_byte(bytes[i], ign);
    endtask

    task automatic test_reset_image();
        send_list('{8'hF0, 8'h0F});
    endtask

    task automatic test_intensity();
        setup_image(FMT_I4, 8, 8);
        send_list('{8'hF0, 8'h0F, 8'h5A});
        setup_image(FMT_I8, 8, 8);
        send_list('{8'h00, 8'hFF});
        setup_image(FMT_IA4, 8, 8);
        send_list('{8'hF0, 8'h0F});
        setup_image(FMT_IA8, 8, 8);
        send_list('{8'h00, 8'hFF, 8'hFF, 8'h00});
    endtask

    task automatic test_color16();
        setup_image(FMT_RGB565, 4, 4);
        send_list('{8'hFF, 8'hFF, 8'hF8, 8'h1F, 8'h07, 8'hE0});
        setup_image(FMT_RGB5A3, 4, 4);
        send_list('{8'h80, 8'h00, 8'hFF, 8'hFF, 8'h7F, 8'hFF, 8'h0A, 8'h5F});
    endtask

    task automatic test_rgba8();
        logic [7:0] bytes[$];
        setup_image(FMT_RGBA8, 3, 3);
        for (int i = 0; i < 64; i++) bytes.push_back(8'($urandom));
        bytes[0] = 8'hFF;
        bytes[1] = 8'h00;
        bytes[32] = 8'h00;
        bytes[33] = 8'hFF;
        send_list(bytes);
    endtask

    task automatic test_cmpr();
        setup_image(FMT_CMPR, 8, 8);
        send_list('{8'hFF, 8'hFF, 8'h00, 8'h00, 8'h1B, 8'hE4, 8'h00, 8'hFF});
        send_list('{8'h00, 8'h00, 8'hFF, 8'hFF, 8'h1B, 8'hE4, 8'h55, 8'hAA});
        send_list('{8'h12, 8'h34, 8'h12, 8'h34, 8'hFF, 8'h00, 8'h39, 8'hC6});
    endtask

    task automatic test_unsupported();
        setup_image(4'd7, 4, 4);
        send_list('{8'h00, 8'hFF});
        setup_image(4'd15, 4, 4);
        send_list('{8'hA5});
    endtask

    task automatic test_finished_image();
        setup_image(FMT_I8, 2, 1);
        send_list('{8'h11, 8'h22, 8'h33, 8'h44});
        write_reg(REG_UNUSED, 15'h7FFF);
        send_list('{8'h55});
        write_reg(REG_WIDTH, 15'd2);
        send_list('{8'h66, 8'h77});
    endtask

    task automatic test_dimensions();
        setup_image(FMT_I8, 0, 0);
        send_list('{8'h01, 8'h02});
        setup_image(FMT_I4, 32767, 32767);
        send_list('{8'h3C, 8'hC3});
        setup_image(FMT_I4, 16384, 16385);
        send_list('{8'h81});
    endtask

    // receiver holds off while bytes keep coming, then sender drains
    task automatic test_backpressure();
        bit ign;
        setup_image(FMT_I4, 16, 16);
        hold_req = 1'b1;
        for (int i = 0; i < 40; i++) send_byte(8'($urandom), ign);
        wait_idle();
    endtask

    task automatic test_random();
        int counted;
        int nbytes;
        int pick;
        logic [3:0] f;
        int w;
        int h;
        bit ign;
        counted = 0;
        while (counted < 80) begin
            pick = $urandom_range(0, 9);
            if (pick <= 6) f = 4'(pick);
            else if (pick == 8) begin
                do f = 4'($urandom_range(7, 15)); while (f == FMT_CMPR);
            end else f = FMT_CMPR;
            if ($urandom_range(0, 9) == 0) w = $urandom_range(0, 32767);
            else w = $urandom_range(1, 20);
            if ($urandom_range(0, 9) == 0) h = $urandom_range(0, 32767);
            else h = $urandom_range(1, 20);
            setup_image(f, w, h);
            nbytes = $urandom_range(8, 40);
            for (int i = 0; i < nbytes; i++) begin
                send_byte(8'($urandom), ign);
                counted++;
            end
        end
    endtask

    always @(negedge aclk) begin
        logic rdy;
        if (hold_req) begin
            hold_cnt = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (pat_left == 0) begin
            pat_mode = $urandom_range(0, 2);
            pat_left = $urandom_range(10, 80);
        end
        pat_left--;
        if (hold_cnt > 0) begin
            hold_cnt--;
            rdy = 1'b0;
        end else if (pat_mode == 0) rdy = 1'b1;
        else if (pat_mode == 1) rdy = $urandom_range(0, 1);
        else rdy = ($urandom_range(0, 4) == 0);
        m_tready <= rdy;
    end

    always @(posedge aclk) begin
        pixel_t got;
        pixel_t want;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t watchdog: no word accepted for %0d cycles", $time, IDLE_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
            if (m_tvalid && m_tready) begin
                got = '0;
                got.x = m_tdata[13:0];
                got.y = m_tdata[27:14];
                got.r = m_tdata[35:28];
                got.g = m_tdata[43:36];
                got.b = m_tdata[51:44];
                got.a = m_tdata[59:52];
                got.done = m_tdata[60];
                got.last = m_tlast;
                got.err = m_tuser;
                if (pixel_q.size() == 0) begin
                    errors++;
                    $display("%0t unexpected word: actual %p", $time, got);
                end else begin
                    want = pixel_q.pop_front();
                    if (got != want || m_tdata[63:61] != '0) begin
                        errors++;
                        $display("%0t mismatch: expected %p actual %p tdata %h",
                                 $time, want, got, m_tdata);
                    end
                end
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_FORMAT;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        errors = 0;
        idle_cycles = 0;
        burst_left = 0;
        hold_req = 1'b0;
        hold_cnt = 0;
        pat_mode = 0;
        pat_left = 0;
        tex_fmt = FMT_I4;
        img_w = 15'd1;
        img_h = 15'd1;
        restart_image();
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;

        test_reset_image();
        test_intensity();
        test_color16();
        test_rgba8();
        test_cmpr();
        test_unsupported();
        test_finished_image();
        test_dimensions();
        test_backpressure();
        test_random();

        wait_idle();
        repeat (20) @(posedge aclk);
        if (errors == 0 && pixel_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: tiled_texture_texel_decoder_unit.f
rtl/core/ttd_pkg.sv
rtl/core/ttd_front.sv
rtl/core/ttd_queue.sv
rtl/core/ttd_back.sv
rtl/core/tiled_texture_texel_decoder_unit.sv
rtl/core/ttd_checker.sv
tb/tb_top.sv
